### rtl/tpi_pkg.sv
// Shared types and constants for the three-plane intersection block.
`timescale 1ns / 1ps

package tpi_pkg;

   localparam int DetW  = 50;   // |det| magnitude width
   localparam int MagW  = 65;   // |numerator| magnitude width
   localparam int QBits = 33;   // quotient bits resolved by the divider
   localparam int RemW  = DetW; // divider remainder width

   // One request handed from the front end to the divider back end
   typedef struct packed {
      logic                       found;
      logic                       dneg;
      logic [DetW-1:0]            dm;
      logic [2:0]                 nneg;
      logic [2:0][MagW-1:0]       mag;
   } qitem_type;

endpackage

### rtl/tpi_front.sv
// Front end: cross products, determinant, numerators and classification.
`timescale 1ns / 1ps

module tpi_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0][2:0][15:0] nrm,
   input  logic [2:0][31:0]      ofs,
   input  logic [46:0]           thr,
   input  logic                  q_full,
   output logic                  stall,
   output logic                  push,
   output tpi_pkg::qitem_type    item
);

   logic        fe_en;
   logic [3:0]  vld_ff;

   logic signed [31:0] pa_ff [3][3];
   logic signed [31:0] pb_ff [3][3];
   logic signed [31:0] pa_in [3][3];
   logic signed [31:0] pb_in [3][3];
   logic [2:0][15:0]   n1_s1_ff, n1_s2_ff;
   logic [2:0][31:0]   d_s1_ff, d_s2_ff;

   logic signed [32:0] c_ff [3][3];
   logic signed [32:0] c_in [3][3];

   logic signed [48:0] dt_ff [3];
   logic signed [48:0] dt_in [3];
   logic signed [64:0] nm_ff [3][3];
   logic signed [64:0] nm_in [3][3];

   logic signed [50:0] det_ff, det_in;
   logic signed [66:0] num_ff [3];
   logic signed [66:0] num_in [3];

   // whole front advances unless its last stage is blocked by a full queue
   assign fe_en = !vld_ff[3] || !q_full;
   assign stall = !fe_en;
   assign push  = vld_ff[3] && !q_full;

   // stage 1: the eighteen normal products of the cross products
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) begin
            pa_in[p][k] = $signed(nrm[(p+1)%3][(k+1)%3]) * $signed(nrm[(p+2)%3][(k+2)%3]);
            pb_in[p][k] = $signed(nrm[(p+1)%3][(k+2)%3]) * $signed(nrm[(p+2)%3][(k+1)%3]);
         end
      end
   end

   // stage 2: cross products; stage 3: det terms and offset products
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) begin
            c_in[p][k] = 33'(pa_ff[p][k]) - 33'(pb_ff[p][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         dt_in[k] = $signed(n1_s2_ff[k]) * c_ff[0][k];
         for (int p = 0; p < 3; p++) begin
            nm_in[p][k] = $signed(d_s2_ff[p]) * c_ff[p][k];
         end
      end
   end

   // stage 4: determinant and numerator sums
   always_comb begin
      det_in = 51'(dt_ff[0]) + 51'(dt_ff[1]) + 51'(dt_ff[2]);
      for (int k = 0; k < 3; k++) begin
         num_in[k] = 67'(nm_ff[0][k]) + 67'(nm_ff[1][k]) + 67'(nm_ff[2][k]);
      end
   end

   // classification and signed magnitudes for the queue
   always_comb begin
      logic signed [66:0] nn;
      logic [50:0]        adet;
      item.dneg = det_ff[50];
      adet      = det_ff[50] ? 51'(-det_ff) : 51'(det_ff);
      item.dm   = adet[tpi_pkg::DetW-1:0];
      item.found = (det_ff != '0) && (adet >= {4'b0, thr});
      for (int k = 0; k < 3; k++) begin
         nn = -num_ff[k];
         item.nneg[k] = nn[66];
         item.mag[k]  = nn[66] ? 65'(-nn) : 65'(nn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (fe_en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (fe_en) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         n1_s1_ff <= nrm[0];
         d_s1_ff  <= ofs;
         c_ff     <= c_in;
         n1_s2_ff <= n1_s1_ff;
         d_s2_ff  <= d_s1_ff;
         dt_ff    <= dt_in;
         nm_ff    <= nm_in;
         det_ff   <= det_in;
         num_ff   <= num_in;
      end
   end

endmodule

### rtl/tpi_queue.sv
// Two-entry queue between front end and divider back end.
`timescale 1ns / 1ps

module tpi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpi_pkg::qitem_type  wr_item,
   input  logic                pop,
   output logic                full,
   output logic                nonempty,
   output tpi_pkg::qitem_type  rd_item
);

   tpi_pkg::qitem_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign nonempty = (cnt_ff != 2'd0);
   assign rd_item  = mem_ff[rp_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

endmodule

### rtl/tpi_back.sv
// Back end: pipelined restoring dividers, saturation and result register.
`timescale 1ns / 1ps

module tpi_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_nonempty,
   input  tpi_pkg::qitem_type  q_item,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_stall,
   output logic                out_found,
   output logic                out_sat,
   output logic [2:0][31:0]    out_point
);

   localparam int NS = tpi_pkg::QBits + 1;

   logic be_en;

   logic [NS-1:0]               vld_ff;
   logic                        found_ff [NS];
   logic [tpi_pkg::DetW-1:0]    dm_ff    [NS];
   logic [tpi_pkg::RemW-1:0]    rem_ff   [3][NS];
   logic [tpi_pkg::RemW-1:0]    rem_in   [3][NS];
   logic [tpi_pkg::QBits-1:0]   low_ff   [3][NS];
   logic [tpi_pkg::QBits-1:0]   low_in   [3][NS];
   logic [tpi_pkg::QBits-1:0]   quo_ff   [3][NS];
   logic [tpi_pkg::QBits-1:0]   quo_in   [3][NS];
   logic                        neg_ff   [3][NS];
   logic                        psat_ff  [3][NS];
   logic                        psat_in  [3];

   logic                        rv_ff, rf_ff, rs_ff;
   logic [2:0][31:0]            rp_ff;
   logic                        rs_in;
   logic [2:0][31:0]            rp_in;

   assign be_en     = !rv_ff || !out_stall;
   assign pop       = be_en && q_nonempty;
   assign out_valid = rv_ff;
   assign out_found = rf_ff;
   assign out_sat   = rs_ff;
   assign out_point = rp_ff;

   // entry stage: scale by 2^14, early overflow check, then one quotient bit per stage
   always_comb begin
      logic [78:0]                 nsc;
      logic [tpi_pkg::RemW:0]      r2;
      logic                        ge;
      for (int l = 0; l < 3; l++) begin
         nsc           = {q_item.mag[l], 14'b0};
         rem_in[l][0]  = {4'b0, nsc[78:33]};
         low_in[l][0]  = nsc[32:0];
         quo_in[l][0]  = '0;
         psat_in[l]    = ({4'b0, nsc[78:33]} >= q_item.dm);
         for (int s = 1; s < NS; s++) begin
            r2 = {rem_ff[l][s-1], low_ff[l][s-1][tpi_pkg::QBits-1]};
            ge = (r2 >= {1'b0, dm_ff[s-1]});
            rem_in[l][s] = ge ? tpi_pkg::RemW'(r2 - {1'b0, dm_ff[s-1]})
                              : r2[tpi_pkg::RemW-1:0];
            low_in[l][s] = {low_ff[l][s-1][tpi_pkg::QBits-2:0], 1'b0};
            quo_in[l][s] = {quo_ff[l][s-1][tpi_pkg::QBits-2:0], ge};
         end
      end
   end

   // clamp and sign the final quotients
   always_comb begin
      logic [tpi_pkg::QBits-1:0] qv;
      logic                      sat;
      rs_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         qv  = quo_ff[l][NS-1];
         sat = psat_ff[l][NS-1] ||
               (neg_ff[l][NS-1] ? (qv > 33'h080000000) : (qv > 33'h07FFFFFFF));
         if (!found_ff[NS-1]) begin
            rp_in[l] = '0;
         end else if (sat) begin
            rp_in[l] = neg_ff[l][NS-1] ? 32'h80000000 : 32'h7FFFFFFF;
         end else begin
            rp_in[l] = neg_ff[l][NS-1] ? -qv[31:0] : qv[31:0];
         end
         rs_in = rs_in || (sat && found_ff[NS-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rv_ff  <= 1'b0;
      end else if (be_en) begin
         vld_ff <= {vld_ff[NS-2:0], q_nonempty};
         rv_ff  <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (be_en) begin
         found_ff[0] <= q_item.found;
         dm_ff[0]    <= q_item.dm;
         for (int s = 1; s < NS; s++) begin
            found_ff[s] <= found_ff[s-1];
            dm_ff[s]    <= dm_ff[s-1];
         end
         for (int l = 0; l < 3; l++) begin
            neg_ff[l][0]  <= q_item.nneg[l] != q_item.dneg;
            psat_ff[l][0] <= psat_in[l];
            for (int s = 1; s < NS; s++) begin
               neg_ff[l][s]  <= neg_ff[l][s-1];
               psat_ff[l][s] <= psat_ff[l][s-1];
            end
            for (int s = 0; s < NS; s++) begin
               rem_ff[l][s] <= rem_in[l][s];
               low_ff[l][s] <= low_in[l][s];
               quo_ff[l][s] <= quo_in[l][s];
            end
         end
         rf_ff <= found_ff[NS-1];
         rs_ff <= rs_in;
         rp_ff <= rp_in;
      end
   end

endmodule

### rtl/three_plane_intersection.sv
// Three-plane intersection by Cramer's rule, top level.
// Path from request accept to result: 4 front stages, queue, 34 divider stages and the
// result register; one request per cycle sustained while rsp_stall does not hold the pipeline.
// Throughput is set by the fully pipelined 33-step restoring divider, one quotient bit a stage.
// Reset (synchronous, active high) empties all stages and the queue; threshold resets to 1.
`timescale 1ns / 1ps

module three_plane_intersection (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [46:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_plane1_normal_x,
   input  logic signed [15:0] req_plane1_normal_y,
   input  logic signed [15:0] req_plane1_normal_z,
   input  logic signed [31:0] req_plane1_offset,
   input  logic signed [15:0] req_plane2_normal_x,
   input  logic signed [15:0] req_plane2_normal_y,
   input  logic signed [15:0] req_plane2_normal_z,
   input  logic signed [31:0] req_plane2_offset,
   input  logic signed [15:0] req_plane3_normal_x,
   input  logic signed [15:0] req_plane3_normal_y,
   input  logic signed [15:0] req_plane3_normal_z,
   input  logic signed [31:0] req_plane3_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic               rsp_saturated,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z
);

   logic [46:0]           thr_ff;
   logic [2:0][2:0][15:0] nrm;
   logic [2:0][31:0]      ofs;
   logic                  q_full, q_nonempty, push, pop;
   tpi_pkg::qitem_type    wr_item, rd_item;
   logic [2:0][31:0]      point;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 47'd1;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign nrm[0] = {req_plane1_normal_z, req_plane1_normal_y, req_plane1_normal_x};
   assign nrm[1] = {req_plane2_normal_z, req_plane2_normal_y, req_plane2_normal_x};
   assign nrm[2] = {req_plane3_normal_z, req_plane3_normal_y, req_plane3_normal_x};
   assign ofs    = {req_plane3_offset, req_plane2_offset, req_plane1_offset};

   tpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .nrm      (nrm),
      .ofs      (ofs),
      .thr      (thr_ff),
      .q_full   (q_full),
      .stall    (req_stall),
      .push     (push),
      .item     (wr_item)
   );

   tpi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_item  (wr_item),
      .pop      (pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .rd_item  (rd_item)
   );

   tpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_item     (rd_item),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_found  (rsp_found),
      .out_sat    (rsp_saturated),
      .out_point  (point)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];

endmodule

### test/tb_three_plane_intersection.sv
// Self-checking testbench for the three-plane intersection block.
`timescale 1ns / 1ps

module tb_three_plane_intersection;

   // Plane triple as driven on the request port
   typedef struct {
      logic signed [15:0] nrm [3][3];
      logic signed [31:0] ofs [3];
   } triple_type;

   // Expected intersection result
   typedef struct {
      logic               found;
      logic               saturated;
      logic signed [31:0] pt [3];
   } point_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [46:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_n [3][3];
   logic signed [31:0] req_d [3];
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_found;
   logic               rsp_saturated;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic signed [31:0] rsp_point_z;

   point_type   expected_points[$];
   logic [46:0] threshold;
   int          errors;
   int          cycles;
   int          n_sent;
   int          n_checked;
   int          n_found;
   int          n_sat;
   bit          hold_off;
   bit          no_idle;

   three_plane_intersection u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_plane1_normal_x (req_n[0][0]),
      .req_plane1_normal_y (req_n[0][1]),
      .req_plane1_normal_z (req_n[0][2]),
      .req_plane1_offset   (req_d[0]),
      .req_plane2_normal_x (req_n[1][0]),
      .req_plane2_normal_y (req_n[1][1]),
      .req_plane2_normal_z (req_n[1][2]),
      .req_plane2_offset   (req_d[1]),
      .req_plane3_normal_x (req_n[2][0]),
      .req_plane3_normal_y (req_n[2][1]),
      .req_plane3_normal_z (req_n[2][2]),
      .req_plane3_offset   (req_d[2]),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_saturated       (rsp_saturated),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_point_z         (rsp_point_z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cramer's rule with exact wide arithmetic, then Q18.14 clamp
   function automatic point_type intersect_planes(triple_type t);
      logic signed [63:0]  n [3][3];
      logic signed [63:0]  c [3][3];
      logic signed [63:0]  det;
      logic signed [127:0] num;
      logic signed [127:0] q;
      point_type           r;
      int                  a;
      int                  b;
      r.found = 1'b0;
      r.saturated = 1'b0;
      for (int k = 0; k < 3; k++) r.pt[k] = '0;
      for (int p = 0; p < 3; p++)
         for (int k = 0; k < 3; k++) n[p][k] = t.nrm[p][k];
      for (int p = 0; p < 3; p++) begin
         a = (p + 1) % 3;
         b = (p + 2) % 3;
         c[p][0] = n[a][1] * n[b][2] - n[a][2] * n[b][1];
         c[p][1] = n[a][2] * n[b][0] - n[a][0] * n[b][2];
         c[p][2] = n[a][0] * n[b][1] - n[a][1] * n[b][0];
      end
      det = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
      if (det == 0 || (det < 0 ? -det : det) < $signed({17'd0, threshold}))
         return r;
      r.found = 1'b1;
      for (int k = 0; k < 3; k++) begin
         num = 128'(t.ofs[0]) * 128'(c[0][k]) + 128'(t.ofs[1]) * 128'(c[1][k])
             + 128'(t.ofs[2]) * 128'(c[2][k]);
         // signed division truncates toward zero
         q = (-num * 128'sd16384) / 128'(det);
         if (q > 128'sh7FFFFFFF) begin
            r.pt[k] = 32'h7FFFFFFF;
            r.saturated = 1'b1;
         end else if (q < -128'sh80000000) begin
            r.pt[k] = 32'h80000000;
            r.saturated = 1'b1;
         end else
            r.pt[k] = q[31:0];
      end
      return r;
   endfunction

   // Cycle counter and limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random stall, a long hold-off on request
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_off)
         rsp_stall <= 1'b1;
      else if (no_idle)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 19);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = expected_points.pop_front();
            n_checked++;
            if (e.found) n_found++;
            if (e.saturated) n_sat++;
            if (rsp_found !== e.found) begin
               $error("found: expected %0d, got %0d", e.found, rsp_found);
               errors++;
            end
            if (rsp_saturated !== e.saturated) begin
               $error("saturated: expected %0d, got %0d", e.saturated, rsp_saturated);
               errors++;
            end
            if (rsp_point_x !== e.pt[0]) begin
               $error("point_x: expected %0d, got %0d", e.pt[0], rsp_point_x);
               errors++;
            end
            if (rsp_point_y !== e.pt[1]) begin
               $error("point_y: expected %0d, got %0d", e.pt[1], rsp_point_y);
               errors++;
            end
            if (rsp_point_z !== e.pt[2]) begin
               $error("point_z: expected %0d, got %0d", e.pt[2], rsp_point_z);
               errors++;
            end
         end
      end
   end

   // Offer one request, with a random gap first unless no_idle is set, and wait for acceptance
   task automatic send_triple(triple_type t);
      if (!no_idle)
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) req_n[p][k] <= t.nrm[p][k];
         req_d[p] <= t.ofs[p];
      end
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_points.push_back(intersect_planes(t));
      n_sent++;
   endtask

   // Threshold write, only with the pipeline drained
   task automatic write_threshold(logic [46:0] v);
      wait_drained();
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold = v;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_normal();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return $signed(16'($urandom_range(32767)) - 16'sd16384);
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic logic signed [31:0] rand_offset();
      case ($urandom_range(4))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(131071)) - 32'sd65536);
         default: return $signed(32'($urandom));
      endcase
   endfunction

   function automatic triple_type rand_triple();
      triple_type t;
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) t.nrm[p][k] = rand_normal();
         t.ofs[p] = rand_offset();
      end
      // sometimes make two planes parallel
      if ($urandom_range(9) == 0) t.nrm[1] = t.nrm[0];
      return t;
   endfunction

   function automatic triple_type axis_triple(logic signed [15:0] s, logic signed [31:0] d);
      triple_type t;
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) t.nrm[p][k] = (p == k) ? s : 16'sd0;
         t.ofs[p] = d;
      end
      return t;
   endfunction

   // Directed: axis planes, extremes, parallel and saturating cases, then eight random triples
   task automatic test_directed();
      triple_type t;
      send_triple(axis_triple(16'sd16384, 32'sd65536));
      send_triple(axis_triple(16'sd16384, 32'sh7FFFFFFF));
      send_triple(axis_triple(16'sh8000, 32'sh80000000));
      send_triple(axis_triple(16'sh7FFF, 32'sh80000000));
      send_triple(axis_triple(16'sd1, 32'sh7FFFFFFF));   // saturates low
      send_triple(axis_triple(16'sd1, 32'sh80000000));   // saturates high
      send_triple(axis_triple(16'sd0, 32'sd5));           // zero determinant
      send_triple(axis_triple(16'shFFFF, 32'sh12345678));
      t = axis_triple(16'sd16384, 32'sd100);
      t.nrm[2] = t.nrm[1];                                // parallel pair
      send_triple(t);
      t = axis_triple(16'sh7FFF, 32'shFFFFFFFF);
      t.nrm[0][1] = 16'sh8000;
      t.nrm[1][2] = 16'sh7FFF;
      send_triple(t);
      for (int i = 0; i < 8; i++) send_triple(rand_triple());
   endtask

   // Threshold sweep including both extremes
   task automatic test_threshold();
      logic [46:0] vals [4];
      vals = '{47'd0, 47'h7FFF_FFFF_FFFF, 47'd1 << 40, 47'd1 << 28};
      foreach (vals[i]) begin
         write_threshold(vals[i]);
         send_triple(axis_triple(16'sd1, 32'sd3));
         send_triple(axis_triple(16'sd16384, 32'sd3));
         send_triple(axis_triple(16'sh8000, 32'sd3));
         for (int j = 0; j < 10; j++) send_triple(rand_triple());
      end
      write_threshold(47'd1);
   endtask

   // Receiver holds off while requests keep coming
   task automatic test_backpressure();
      no_idle = 1'b1;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 80; i++) send_triple(rand_triple());
      join
      no_idle = 1'b0;
   endtask

   // Random stream, with a stretch of back-to-back traffic and a random threshold write
   task automatic test_random();
      for (int i = 0; i < 500; i++) begin
         no_idle = (i >= 200 && i < 300);
         if (i == 300) write_threshold(47'($urandom) << ($urandom_range(15)));
         send_triple(rand_triple());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      n_sent = 0;
      n_checked = 0;
      n_found = 0;
      n_sat = 0;
      hold_off = 1'b0;
      no_idle = 1'b0;
      threshold = 47'd1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 3; k++) req_n[p][k] = '0;
         req_d[p] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold();
      test_backpressure();
      test_random();
      wait_drained();
      $display("Sent %0d plane triples, checked %0d results", n_sent, n_checked);
      $display("%0d intersections found, %0d clamped", n_found, n_sat);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
